// ===== rtl/lla_pkg.sv =====
// Shared constants, codes and payload types for the array-pool linked list engine.
package lla_pkg;

	localparam int POOL_DEPTH = 256;
	localparam int IDX_W      = $clog2(POOL_DEPTH);
	localparam int PTR_W      = $clog2(POOL_DEPTH + 1);
	localparam int VALUE_W    = 32;
	localparam int OP_W       = 3;
	localparam int POS_W      = 8;
	localparam int STATUS_W   = 3;
	localparam int CNT_W      = (PTR_W > POS_W) ? PTR_W : POS_W;

	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_POS   = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_END   = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_END   = 3'd5;
	localparam logic [OP_W-1:0] OP_SEARCH    = 3'd6;

	localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BEYOND    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]           operation;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} lla_in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    found_position;
	} lla_out_t;

	// One shared address serves both pool memories.
	typedef struct packed {
		logic               val_we;
		logic               link_we;
		logic [IDX_W-1:0]   addr;
		logic [VALUE_W-1:0] val_wdata;
		logic [PTR_W-1:0]   link_wdata;
	} lla_mem_req_t;

endpackage

// ===== rtl/lla_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
module lla_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/lla_seq.sv =====
// Operation sequencer: walks the list through the pool memories and applies each edit.
module lla_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        op_valid,
	output logic                        op_ready,
	input  lla_pkg::lla_in_t            op,
	output lla_pkg::lla_mem_req_t       mem_req,
	input  logic [lla_pkg::VALUE_W-1:0] val_rdata,
	input  logic [lla_pkg::PTR_W-1:0]   link_rdata,
	output logic                        resp_valid,
	input  logic                        resp_ready,
	output lla_pkg::lla_out_t           resp
);
	import lla_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_NODE = 3'd2;
	localparam logic [2:0] S_LINK = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]          state_q;
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    free_q;
	logic [OP_W-1:0]     op_q;
	logic [VALUE_W-1:0]  val_q;
	logic [CNT_W-1:0]    tgt_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PTR_W-1:0]    cur_q;
	logic [PTR_W-1:0]    prv_q;
	logic [PTR_W-1:0]    nlink_q;
	logic                set_head_q;
	logic [STATUS_W-1:0] st_q;
	logic [POS_W-1:0]    fnd_q;

	logic [PTR_W-1:0]    nxt;
	logic                nxt_null;
	logic                prv_null;
	logic                at_tgt;
	logic                hit;
	logic                accept;
	logic                w_adv;
	logic                w_node;
	logic                w_fin;
	logic                w_wr_link;
	logic                w_set_head;
	logic [PTR_W-1:0]    w_nlink;
	logic [PTR_W-1:0]    w_head;
	logic [STATUS_W-1:0] w_st;
	logic [CNT_W-1:0]    pos_ext;

	assign nxt        = link_rdata[PTR_W-1:0];
	assign nxt_null   = (nxt == NULL_PTR);
	assign prv_null   = (prv_q == NULL_PTR);
	assign at_tgt     = (cnt_q == tgt_q);
	assign hit        = (val_rdata[VALUE_W-1:0] == val_q);
	assign op_ready   = (state_q == S_IDLE);
	assign accept     = op_valid && op_ready;
	assign resp_valid = (state_q == S_RESP);
	assign pos_ext    = CNT_W'(op.position);

	assign resp.status         = st_q;
	assign resp.found_position = fnd_q;

	// Per-node decision while walking; link and value data belong to cur_q.
	always_comb begin
		w_adv      = 1'b0;
		w_node     = 1'b0;
		w_fin      = 1'b0;
		w_wr_link  = 1'b0;
		w_set_head = 1'b0;
		w_nlink    = NULL_PTR;
		w_head     = NULL_PTR;
		w_st       = ST_DONE;
		unique case (op_q) inside
			OP_INS_POS: begin
				if (at_tgt) begin
					w_node  = 1'b1;
					w_nlink = nxt;
				end else if (nxt_null) begin
					w_fin = 1'b1;
					w_st  = ST_BEYOND;
				end else begin
					w_adv = 1'b1;
				end
			end
			OP_INS_END: begin
				if (nxt_null) begin
					w_node = 1'b1;
				end else begin
					w_adv = 1'b1;
				end
			end
			OP_DEL_FRONT, OP_DEL_POS: begin
				if (at_tgt) begin
					w_fin = 1'b1;
					if (prv_null) begin
						w_set_head = 1'b1;
						w_head     = nxt;
					end else begin
						w_wr_link = 1'b1;
						w_nlink   = nxt;
					end
				end else if (nxt_null) begin
					w_fin = 1'b1;
					w_st  = ST_BEYOND;
				end else begin
					w_adv = 1'b1;
				end
			end
			OP_DEL_END: begin
				if (nxt_null) begin
					w_fin = 1'b1;
					if (prv_null) begin
						w_set_head = 1'b1;
					end else begin
						w_wr_link = 1'b1;
					end
				end else begin
					w_adv = 1'b1;
				end
			end
			OP_SEARCH: begin
				if (hit) begin
					w_fin = 1'b1;
				end else if (nxt_null) begin
					w_fin = 1'b1;
					w_st  = ST_NOT_FOUND;
				end else begin
					w_adv = 1'b1;
				end
			end
			default: begin
				w_fin = 1'b1;
			end
		endcase
	end

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_req.addr = head_q[IDX_W-1:0];
			end
			S_WALK: begin
				if (w_adv) begin
					mem_req.addr = nxt[IDX_W-1:0];
				end else if (w_wr_link) begin
					mem_req.link_we    = 1'b1;
					mem_req.addr       = prv_q[IDX_W-1:0];
					mem_req.link_wdata = w_nlink;
				end
			end
			S_NODE: begin
				mem_req.val_we     = 1'b1;
				mem_req.link_we    = 1'b1;
				mem_req.addr       = free_q[IDX_W-1:0];
				mem_req.val_wdata  = val_q;
				mem_req.link_wdata = nlink_q;
			end
			S_LINK: begin
				mem_req.link_we    = 1'b1;
				mem_req.addr       = cur_q[IDX_W-1:0];
				mem_req.link_wdata = free_q;
			end
			default: begin
			end
		endcase
	end

	// Control state: sequencer, head and bump allocator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NULL_PTR;
			free_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op.operation) inside
							OP_INS_FRONT, OP_INS_POS, OP_INS_END: begin
								if (free_q == NULL_PTR) begin
									state_q <= S_RESP;
								end else if (op.operation == OP_INS_FRONT ||
										(op.operation == OP_INS_POS && op.position == '0)) begin
									state_q <= S_NODE;
								end else if (head_q == NULL_PTR) begin
									state_q <= (op.operation == OP_INS_POS) ? S_RESP : S_NODE;
								end else begin
									state_q <= S_WALK;
								end
							end
							OP_DEL_FRONT, OP_DEL_POS, OP_DEL_END, OP_SEARCH: begin
								state_q <= (head_q == NULL_PTR) ? S_RESP : S_WALK;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_WALK: begin
					if (w_node) begin
						state_q <= S_NODE;
					end else if (w_fin) begin
						state_q <= S_RESP;
						if (w_set_head) begin
							head_q <= w_head;
						end
					end
				end
				S_NODE: begin
					if (set_head_q) begin
						head_q  <= free_q;
						free_q  <= free_q + 1'b1;
						state_q <= S_RESP;
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					free_q  <= free_q + 1'b1;
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (resp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operation context and walk cursor.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q       <= op.operation;
					val_q      <= op.value;
					cur_q      <= head_q;
					prv_q      <= NULL_PTR;
					cnt_q      <= '0;
					fnd_q      <= '0;
					set_head_q <= 1'b0;
					nlink_q    <= NULL_PTR;
					st_q       <= ST_DONE;
					if (op.operation == OP_INS_POS) begin
						tgt_q <= pos_ext - 1'b1;
					end else if (op.operation == OP_DEL_POS) begin
						tgt_q <= pos_ext;
					end else begin
						tgt_q <= '0;
					end
					unique case (op.operation) inside
						OP_INS_FRONT, OP_INS_POS, OP_INS_END: begin
							if (free_q == NULL_PTR) begin
								st_q <= ST_FULL;
							end else if (op.operation == OP_INS_FRONT ||
									(op.operation == OP_INS_POS && op.position == '0)) begin
								set_head_q <= 1'b1;
								nlink_q    <= head_q;
							end else if (head_q == NULL_PTR) begin
								if (op.operation == OP_INS_POS) begin
									st_q <= ST_BEYOND;
								end else begin
									set_head_q <= 1'b1;
								end
							end
						end
						OP_DEL_FRONT, OP_DEL_POS, OP_DEL_END: begin
							if (head_q == NULL_PTR) begin
								st_q <= ST_EMPTY;
							end
						end
						OP_SEARCH: begin
							if (head_q == NULL_PTR) begin
								st_q <= ST_NOT_FOUND;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				if (w_adv) begin
					cur_q <= nxt;
					prv_q <= cur_q;
					cnt_q <= cnt_q + 1'b1;
				end else begin
					nlink_q <= w_nlink;
					st_q    <= w_st;
					if (op_q == OP_SEARCH && hit) begin
						fnd_q <= cnt_q[POS_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/linked_list_array_pool_engine_unit.sv =====
// Top level of the array-pool singly linked list engine.
// Usage:
//   Operation channel (op_valid/op_ready/op) takes one operation per transfer:
//   insert front, at position or at end, delete front, at position or at end,
//   or search for a value. Result channel (res_valid/res_ready/res) returns one
//   status and found position per operation, in order.
// Operation flow:
//   One operation is worked at a time. List nodes are visited one by one,
//   bounded by the single read port of the value and link memories. Insert at
//   front goes from the accept straight to the node write and the result; a
//   walking operation visits nodes until it reaches its node, then an insert
//   writes the new node and the link. Rejected operations (pool full, empty list) go straight to the result.
// Reset:
//   arst_n empties the list and rewinds the allocator; memories are not
//   cleared, since only written nodes are ever linked.
// Stall:
//   A finished result waits in the output register while the next operation
//   is already taken; a second result holds the sequencer until res_ready.
module linked_list_array_pool_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  lla_pkg::lla_in_t  op,
	output logic              res_valid,
	input  logic              res_ready,
	output lla_pkg::lla_out_t res
);
	import lla_pkg::*;

	lla_mem_req_t       mem_req;
	logic [VALUE_W-1:0] val_rdata;
	logic [PTR_W-1:0]   link_rdata;
	logic               resp_valid;
	logic               resp_ready;
	lla_out_t           resp;
	logic               res_valid_q;
	lla_out_t           res_q;

	lla_ram #(
		.DEPTH (POOL_DEPTH),
		.WIDTH (VALUE_W)
	) u_val_ram (
		.clk   (clk),
		.we    (mem_req.val_we),
		.addr  (mem_req.addr),
		.wdata (mem_req.val_wdata),
		.rdata (val_rdata)
	);

	lla_ram #(
		.DEPTH (POOL_DEPTH),
		.WIDTH (PTR_W)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_req.link_we),
		.addr  (mem_req.addr),
		.wdata (mem_req.link_wdata),
		.rdata (link_rdata)
	);

	lla_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.op_valid   (op_valid),
		.op_ready   (op_ready),
		.op         (op),
		.mem_req    (mem_req),
		.val_rdata  (val_rdata),
		.link_rdata (link_rdata),
		.resp_valid (resp_valid),
		.resp_ready (resp_ready),
		.resp       (resp)
	);

	// Output register: load when empty or being drained this cycle.
	assign resp_ready = !res_valid_q || res_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (resp_ready) begin
			res_valid_q <= resp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_ready && resp_valid) begin
			res_q <= resp;
		end
	end

endmodule

// ===== sim/testbench.sv =====
// Randomized self-checking testbench for the array-pool linked list engine.
module testbench;
	import lla_pkg::*;

	localparam logic [OP_W-1:0] OP_UNDEFINED = 3'd7;
	localparam int RANDOM_OPS = 830;

	typedef struct packed {
		logic    drain_first;
		lla_in_t item;
	} queued_op_t;

	typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_BURSTY} ready_mode_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     op_valid = 1'b0;
	logic     op_ready;
	lla_in_t  op = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	lla_out_t res;

	linked_list_array_pool_engine_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// expected pool contents
	logic [VALUE_W-1:0] pool_value [POOL_DEPTH];
	logic [PTR_W-1:0]   pool_link [POOL_DEPTH];
	logic [PTR_W-1:0]   list_head;
	logic [PTR_W-1:0]   alloc_next;

	queued_op_t         ops_to_send [$];
	lla_out_t           answers_due [$];
	// plain copy of the list contents, used only to steer the stimulus
	logic [VALUE_W-1:0] list_image [$];
	int                 slots_used = 0;

	int          predicted_total;
	int          checked_total;
	int          error_count = 0;
	int          burst_left;
	int          gap_left;
	int          mode_left;
	int          stall_left;
	ready_mode_t ready_mode;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [PTR_W-1:0] next_node(logic [PTR_W-1:0] n);
		if (n >= NULL_PTR)
			return NULL_PTR;
		return pool_link[n[IDX_W-1:0]];
	endfunction

	function automatic logic [PTR_W-1:0] node_at(int steps);
		logic [PTR_W-1:0] p;
		p = list_head;
		for (int k = 0; k < steps && p != NULL_PTR; k++)
			p = next_node(p);
		return p;
	endfunction

	function automatic logic [PTR_W-1:0] claim_node(logic [VALUE_W-1:0] val,
			logic [PTR_W-1:0] link);
		logic [PTR_W-1:0] n;
		n = alloc_next;
		pool_value[n[IDX_W-1:0]] = val;
		pool_link[n[IDX_W-1:0]] = link;
		alloc_next = alloc_next + 1'b1;
		return n;
	endfunction

	// Apply one operation to the expected pool and return its answer.
	function automatic lla_out_t apply_operation(lla_in_t req);
		lla_out_t         r;
		logic [PTR_W-1:0] p;
		int               idx;
		r = '0;
		r.status = ST_DONE;
		case (req.operation)
		OP_INS_FRONT, OP_INS_POS, OP_INS_END: begin
			if (alloc_next >= NULL_PTR) begin
				r.status = ST_FULL;
			end else if (req.operation == OP_INS_FRONT ||
					(req.operation == OP_INS_POS && req.position == '0)) begin
				list_head = claim_node(req.value, list_head);
			end else if (req.operation == OP_INS_POS) begin
				p = node_at(int'(req.position) - 1);
				if (p == NULL_PTR)
					r.status = ST_BEYOND;
				else
					pool_link[p[IDX_W-1:0]] = claim_node(req.value, next_node(p));
			end else if (list_head == NULL_PTR) begin
				list_head = claim_node(req.value, NULL_PTR);
			end else begin
				p = list_head;
				while (next_node(p) != NULL_PTR)
					p = next_node(p);
				pool_link[p[IDX_W-1:0]] = claim_node(req.value, NULL_PTR);
			end
		end
		OP_DEL_FRONT, OP_DEL_POS, OP_DEL_END: begin
			if (list_head == NULL_PTR) begin
				r.status = ST_EMPTY;
			end else if (req.operation == OP_DEL_FRONT ||
					(req.operation == OP_DEL_POS && req.position == '0)) begin
				list_head = next_node(list_head);
			end else if (req.operation == OP_DEL_POS) begin
				p = node_at(int'(req.position) - 1);
				if (p == NULL_PTR || next_node(p) == NULL_PTR)
					r.status = ST_BEYOND;
				else
					pool_link[p[IDX_W-1:0]] = next_node(next_node(p));
			end else if (next_node(list_head) == NULL_PTR) begin
				list_head = NULL_PTR;
			end else begin
				p = list_head;
				while (next_node(next_node(p)) != NULL_PTR)
					p = next_node(p);
				pool_link[p[IDX_W-1:0]] = NULL_PTR;
			end
		end
		OP_SEARCH: begin
			r.status = ST_NOT_FOUND;
			p = list_head;
			idx = 0;
			while (p != NULL_PTR) begin
				if (pool_value[p[IDX_W-1:0]] == req.value) begin
					r.status = ST_DONE;
					r.found_position = idx[POS_W-1:0];
					break;
				end
				p = next_node(p);
				idx++;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic queue_op(input logic [OP_W-1:0] code, input logic [VALUE_W-1:0] val,
			input logic [POS_W-1:0] pos, input bit drain_first);
		queued_op_t q;
		int         len;
		q.drain_first = drain_first;
		q.item.operation = code;
		q.item.value = val;
		q.item.position = pos;
		ops_to_send.push_back(q);
		len = list_image.size();
		case (code)
		OP_INS_FRONT, OP_INS_POS, OP_INS_END: begin
			if (slots_used < POOL_DEPTH) begin
				if (code == OP_INS_FRONT) begin
					list_image.push_front(val);
					slots_used++;
				end else if (code == OP_INS_END) begin
					list_image.push_back(val);
					slots_used++;
				end else if (int'(pos) <= len) begin
					list_image.insert(int'(pos), val);
					slots_used++;
				end
			end
		end
		OP_DEL_FRONT: if (len != 0) list_image.pop_front();
		OP_DEL_POS:   if (int'(pos) < len) list_image.delete(int'(pos));
		OP_DEL_END:   if (len != 0) list_image.pop_back();
		default: ;
		endcase
	endtask

	function automatic logic [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 15))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return '0;
		3: return '1;
		default: return $urandom();
		endcase
	endfunction

	function automatic logic [POS_W-1:0] clip_position(int x);
		return (x > 255) ? 8'd255 : x[POS_W-1:0];
	endfunction

	// Sender: bursts of transfers with random gaps; a marked item waits for a full drain.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_valid <= 1'b0;
			op <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!op_valid || op_ready) begin
			if (gap_left != 0) begin
				op_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (ops_to_send.size() != 0 && !(ops_to_send[0].drain_first &&
					(op_valid || predicted_total != checked_total))) begin
				op_valid <= 1'b1;
				op <= ops_to_send[0].item;
				ops_to_send.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				op_valid <= 1'b0;
			end
		end
	end

	// Receiver: predict on operation transfers, check on result transfers, stall by mode.
	always @(posedge clk or negedge arst_n) begin
		lla_out_t want;
		if (!arst_n) begin
			list_head = NULL_PTR;
			alloc_next = '0;
			predicted_total <= 0;
			checked_total <= 0;
			res_ready <= 1'b0;
			mode_left <= 0;
			stall_left <= 0;
			ready_mode <= READY_ALWAYS;
		end else begin
			// check before predicting so a stray result cannot match a fresh expectation
			if (res_valid && res_ready) begin
				if (answers_due.size() == 0) begin
					$error("unexpected result: status %0d, found_position %0d",
						res.status, res.found_position);
					error_count++;
				end else begin
					want = answers_due.pop_front();
					if (res.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, res.status);
						error_count++;
					end
					if (res.found_position !== want.found_position) begin
						$error("found_position: expected %0d, actual %0d",
							want.found_position, res.found_position);
						error_count++;
					end
				end
				checked_total <= checked_total + 1;
			end
			if (op_valid && op_ready) begin
				answers_due.push_back(apply_operation(op));
				predicted_total <= predicted_total + 1;
			end

			if (mode_left == 0) begin
				ready_mode <= ready_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(50, 400);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
			READY_ALWAYS: res_ready <= 1'b1;
			READY_HALF:   res_ready <= 1'($urandom_range(0, 1));
			READY_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_left != 0) begin
					res_ready <= 1'b0;
					stall_left <= stall_left - 1;
				end else if ($urandom_range(0, 15) == 0) begin
					res_ready <= 1'b0;
					stall_left <= $urandom_range(5, 40);
				end else begin
					res_ready <= 1'b1;
				end
			end
			endcase
		end
	end

	initial begin
		int                 len;
		int                 pick;
		logic [OP_W-1:0]    code;
		logic [VALUE_W-1:0] val;
		logic [POS_W-1:0]   pos;

		// empty list: every delete and search is refused
		queue_op(OP_SEARCH, 32'h0, 8'h00, 1'b0);
		queue_op(OP_DEL_FRONT, 32'h0, 8'hff, 1'b0);
		queue_op(OP_DEL_POS, 32'h0, 8'h00, 1'b0);
		queue_op(OP_DEL_POS, 32'hffff_ffff, 8'hff, 1'b0);
		queue_op(OP_DEL_END, 32'h0, 8'h00, 1'b0);
		// append onto an empty list, then remove the only node
		queue_op(OP_INS_END, 32'h7fff_ffff, 8'h00, 1'b0);
		queue_op(OP_DEL_END, 32'h0, 8'h00, 1'b0);
		queue_op(OP_INS_POS, 32'h1111_1111, 8'h01, 1'b0);
		// build a short list through every insert flavor
		queue_op(OP_INS_FRONT, 32'h8000_0000, 8'hff, 1'b0);
		queue_op(OP_INS_POS, 32'h0, 8'h00, 1'b0);
		queue_op(OP_INS_POS, 32'hffff_ffff, 8'h02, 1'b0);
		queue_op(OP_INS_POS, 32'h2222_2222, 8'hff, 1'b0);
		queue_op(OP_INS_POS, 32'h3333_3333, 8'h04, 1'b0);
		queue_op(OP_INS_END, 32'h5a5a_5a5a, 8'h00, 1'b0);
		queue_op(OP_INS_POS, 32'ha5a5_a5a5, 8'h01, 1'b0);
		// searches: hit in the middle, hit at the head, miss
		queue_op(OP_SEARCH, 32'hffff_ffff, 8'h00, 1'b0);
		queue_op(OP_SEARCH, 32'h0, 8'hff, 1'b0);
		queue_op(OP_SEARCH, 32'h1234_5678, 8'h00, 1'b0);
		// deletes at and past the end, then at the tail and the head
		queue_op(OP_DEL_POS, 32'h0, 8'h05, 1'b0);
		queue_op(OP_DEL_POS, 32'h0, 8'hff, 1'b0);
		queue_op(OP_DEL_POS, 32'h0, 8'h04, 1'b0);
		queue_op(OP_DEL_POS, 32'h0, 8'h00, 1'b0);
		queue_op(OP_DEL_FRONT, 32'h0, 8'h00, 1'b0);
		queue_op(OP_UNDEFINED, 32'hffff_ffff, 8'hff, 1'b0);
		queue_op(OP_DEL_END, 32'h0, 8'h00, 1'b0);

		// random inserts, deletes and searches; inserts outweigh deletes, so the pool runs out on a long list
		for (int n = 0; n < RANDOM_OPS; n++) begin
			len = list_image.size();
			pick = $urandom_range(0, 99);
			val = random_value();
			pos = POS_W'($urandom_range(0, 255));
			if (pick < 48) begin
				case ($urandom_range(0, 2))
				0: code = OP_INS_FRONT;
				1: code = OP_INS_POS;
				default: code = OP_INS_END;
				endcase
				if (code == OP_INS_POS && $urandom_range(0, 6) != 0)
					pos = clip_position($urandom_range(0, len));
			end else if (pick < 68) begin
				case ($urandom_range(0, 2))
				0: code = OP_DEL_FRONT;
				1: code = OP_DEL_POS;
				default: code = OP_DEL_END;
				endcase
				if (code == OP_DEL_POS && len != 0 && $urandom_range(0, 6) != 0)
					pos = clip_position($urandom_range(0, len - 1));
			end else if (pick < 98) begin
				code = OP_SEARCH;
				if (len != 0 && $urandom_range(0, 2) != 0)
					val = list_image[$urandom_range(0, len - 1)];
			end else begin
				code = OP_UNDEFINED;
			end
			queue_op(code, val, pos, n == 0 || $urandom_range(0, 99) == 0);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (ops_to_send.size() != 0 || op_valid || predicted_total != checked_total);
		repeat (POOL_DEPTH + 16) @(posedge clk);

		if (answers_due.size() != 0) begin
			$error("%0d operations never answered", answers_due.size());
			error_count++;
		end
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
